>>> design/sbd_pkg.sv
// Package for the SYN response bloom dedup block: constants, codes, types.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package sbd_pkg;
    localparam int BLOOM_INDEX_BITS_DEF = 20;
    localparam int PREFIX_W   = 25;
    localparam int INDEX_W    = 15;
    localparam int OFFSET_W   = 15;
    localparam logic [15:0] PORT_BASE    = 16'd40000;
    localparam logic [15:0] PORT_LIMIT   = 16'd60000;
    localparam logic [15:0] MIN_FRAME    = 16'd74;
    localparam logic [15:0] ETHERTYPE_V6 = 16'h86DD;
    localparam logic [7:0]  NEXT_TCP     = 8'd6;
    localparam logic [31:0] SEED_ONE     = 32'h12345678;
    localparam logic [31:0] SEED_TWO     = 32'h87654321;
    localparam logic [31:0] C1 = 32'hcc9e2d51;
    localparam logic [31:0] C2 = 32'h1b873593;
    localparam logic [31:0] C3 = 32'he6546b64;
    localparam logic [31:0] F1 = 32'h85ebca6b;
    localparam logic [31:0] F2 = 32'hc2b2ae35;
    localparam logic [1:0] ST_NEW = 2'd0;
    localparam logic [1:0] ST_DUP = 2'd1;
    localparam logic [1:0] ST_BAD = 2'd2;

    typedef struct packed {
        logic start;
        logic [31:0] seed;
    } t_hash_req;

    function automatic logic [31:0] rotl(input logic [31:0] v, input int r);
        rotl = (v << r) | (v >> (32 - r));
    endfunction
endpackage
`default_nettype wire

>>> design/sbd_ram.sv
// Generic single-port RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module sbd_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 1024
) (
    input  wire                     i_clk,
    input  wire                     i_we,
    input  wire [$clog2(DEPTH)-1:0] i_addr,
    input  wire [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]        o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_addr] <= i_wdata;
        o_rdata <= r_mem[i_addr];
    end
endmodule
`default_nettype wire

>>> design/sbd_hash.sv
// Iterative MurmurHash3_x86_32 over a 16-byte key; one shared 32x32 multiplier.
// Depends on sbd_pkg.
`timescale 1ns / 1ps
`default_nettype none
module sbd_hash (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire sbd_pkg::t_hash_req  i_req,
    input  wire [127:0]              i_key,
    output logic                     o_done,
    output logic [31:0]              o_hash
);
    import sbd_pkg::*;
    // step: per block k*c1, k*c2, h*5; then finalize
    localparam logic [3:0] S_IDLE = 4'd0, S_K1 = 4'd1, S_K2 = 4'd2, S_H = 4'd3,
                           S_F0 = 4'd4, S_F1 = 4'd5, S_F2 = 4'd6, S_DONE = 4'd7;
    logic [3:0]  r_state, n_state;
    logic [1:0]  r_blk, n_blk;
    logic [31:0] r_h, n_h, r_k, n_k;
    logic [31:0] w_a, w_b, w_p, w_kin;
    logic [7:0]  w_b0, w_b1, w_b2, w_b3;

    // block i takes key bytes 4i..4i+3, little endian; byte 0 in bits 127:120
    always_comb begin
        w_b0 = i_key[127 - 32*r_blk -: 8];
        w_b1 = i_key[119 - 32*r_blk -: 8];
        w_b2 = i_key[111 - 32*r_blk -: 8];
        w_b3 = i_key[103 - 32*r_blk -: 8];
        w_kin = {w_b3, w_b2, w_b1, w_b0};
    end

    always_comb begin
        unique case (r_state)
            S_K1:    begin w_a = w_kin; w_b = C1; end
            S_K2:    begin w_a = rotl(r_k, 15); w_b = C2; end
            S_H:     begin w_a = rotl(r_h ^ r_k, 13); w_b = 32'd5; end
            S_F0:    begin w_a = r_h ^ (r_h >> 16); w_b = F1; end
            S_F1:    begin w_a = r_h ^ (r_h >> 13); w_b = F2; end
            default: begin w_a = '0; w_b = '0; end
        endcase
        w_p = w_a * w_b;
    end

    always_comb begin
        n_state = r_state; n_blk = r_blk; n_h = r_h; n_k = r_k;
        unique case (r_state)
            S_IDLE: if (i_req.start) begin
                n_h = i_req.seed; n_blk = '0; n_state = S_K1;
            end
            S_K1: begin n_k = w_p; n_state = S_K2; end
            S_K2: begin n_k = w_p; n_state = S_H; end
            S_H: begin
                n_h = w_p + C3;
                n_blk = r_blk + 2'd1;
                if (r_blk == 2'd3) begin
                    n_h = (w_p + C3) ^ 32'd16;
                    n_state = S_F0;
                end else n_state = S_K1;
            end
            S_F0: begin n_h = w_p; n_state = S_F1; end
            S_F1: begin n_h = w_p; n_state = S_F2; end
            S_F2: begin n_h = r_h ^ (r_h >> 16); n_state = S_DONE; end
            // a new request may follow right on the done cycle
            S_DONE: if (i_req.start) begin
                n_h = i_req.seed; n_blk = '0; n_state = S_K1;
            end else n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else r_state <= n_state;
        r_blk <= n_blk; r_h <= n_h; r_k <= n_k;
    end

    assign o_done = (r_state == S_DONE);
    assign o_hash = r_h;
endmodule
`default_nettype wire

>>> design/syn_response_bloom_dedup_top.sv
// Top level of the SYN response bloom dedup block: sequencer, APB register,
// modulo step, bloom RAM. Depends on sbd_pkg, sbd_hash, sbd_ram.
// One header is taken at a time. A valid header passes through the check,
// 15 restoring subtract steps for the prefix modulo, two passes of the shared
// hash multiplier, two bloom RAM reads and up to two writes (none for a
// duplicate) through its single port, and the output state; an invalid header
// goes from the check straight to the output state. A result held by a stalled
// receiver adds its stall. After reset a clearing pass writes every bloom bit,
// during which no header is accepted. Results sit in an output register.
`timescale 1ns / 1ps
`default_nettype none
module syn_response_bloom_dedup_top #(
    parameter int BLOOM_INDEX_BITS = sbd_pkg::BLOOM_INDEX_BITS_DEF
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          psel,
    input  wire          penable,
    input  wire          pwrite,
    input  wire [0:0]    paddr,
    input  wire [31:0]   pwdata,
    output logic [31:0]  prdata,
    output logic         pready,
    input  wire          s_axis_tvalid,
    output logic         s_axis_tready,
    // tdata: frame_length[15:0], ether_type[31:16], nxt_hdr[39:32],
    // dest_port[55:40], flag_syn[56], flag_ack[57], flag_rst[58],
    // src_addr_high[122:59], src_addr_low[186:123], zeros up to 191
    input  wire [191:0]  s_axis_tdata,
    output logic         m_axis_tvalid,
    input  wire          m_axis_tready,
    // tdata: status[1:0], pfx_index[16:2], target_high[80:17],
    // target_low[144:81], zeros up to 151
    output logic [151:0] m_axis_tdata
);
    import sbd_pkg::*;
    localparam int DEPTH = 2 ** BLOOM_INDEX_BITS;

    localparam logic [3:0] S_CLR = 4'd0, S_IDLE = 4'd1, S_CHK = 4'd2, S_MOD = 4'd3,
        S_H1 = 4'd4, S_H2 = 4'd5, S_RD1 = 4'd6, S_RD2 = 4'd7, S_RW = 4'd8,
        S_WR1 = 4'd9, S_WR2 = 4'd10, S_OUT = 4'd11, S_REQ = 4'd12;

    logic [3:0]  r_state, n_state;
    logic [PREFIX_W-1:0] r_pcount;
    logic [BLOOM_INDEX_BITS-1:0] r_clr;
    logic [191:0] r_in;
    logic [PREFIX_W-1:0] r_rem;
    logic [3:0]  r_bit;
    logic [BLOOM_INDEX_BITS-1:0] r_p1, r_p2;
    logic        r_b1;
    logic [1:0]  r_status;
    logic        r_ovalid;
    t_hash_req   w_req;
    logic        w_hdone;
    logic [31:0] w_hash;
    logic        w_we, w_rd;
    logic [BLOOM_INDEX_BITS-1:0] w_addr;
    logic [PREFIX_W:0] w_trial;

    wire [15:0] w_len = r_in[15:0];
    wire [15:0] w_et  = r_in[31:16];
    wire [7:0]  w_nh  = r_in[39:32];
    wire [15:0] w_port = r_in[55:40];
    wire [127:0] w_key = {r_in[122:59], r_in[186:123]};
    wire [OFFSET_W-1:0] w_off = OFFSET_W'(w_port - PORT_BASE);
    wire w_ok = (w_len >= MIN_FRAME) && (w_et == ETHERTYPE_V6) && (w_nh == NEXT_TCP)
        && (w_port >= PORT_BASE) && (w_port < PORT_LIMIT)
        && ((r_in[56] && r_in[57]) || r_in[58]) && (r_pcount != '0);

    assign pready = 1'b1;
    assign prdata = (paddr == 1'b0) ? {7'd0, r_pcount} : 32'd0;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_pcount <= '0;
        else if (psel && penable && pwrite && paddr == 1'b0) r_pcount <= pwdata[PREFIX_W-1:0];
    end

    sbd_hash u_hash (.i_clk, .i_rst_n, .i_req(w_req), .i_key(w_key),
                     .o_done(w_hdone), .o_hash(w_hash));

    sbd_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_bloom (.i_clk, .i_we(w_we), .i_addr(w_addr),
        .i_wdata(r_state != S_CLR), .o_rdata(w_rd));

    assign w_trial = {r_rem, w_off[r_bit]} - {1'b0, r_pcount};

    always_comb begin
        w_req.start = 1'b0; w_req.seed = SEED_ONE;
        if (r_state == S_REQ) w_req.start = 1'b1;
        if (r_state == S_H1 && w_hdone) begin w_req.start = 1'b1; w_req.seed = SEED_TWO; end
        w_we = 1'b0; w_addr = r_p1;
        unique case (r_state)
            S_CLR: begin w_we = 1'b1; w_addr = r_clr; end
            S_RD2: w_addr = r_p2;
            S_WR1: w_we = 1'b1;
            S_WR2: begin w_we = 1'b1; w_addr = r_p2; end
            default: ;
        endcase
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLR:  if (r_clr == '1) n_state = S_IDLE;
            S_IDLE: if (s_axis_tvalid) n_state = S_CHK;
            S_CHK:  n_state = w_ok ? S_MOD : S_OUT;
            S_MOD:  if (r_bit == 4'd0) n_state = S_REQ;
            S_REQ:  n_state = S_H1;
            S_H1:   if (w_hdone) n_state = S_H2;
            S_H2:   if (w_hdone) n_state = S_RD1;
            S_RD1:  n_state = S_RD2;
            S_RD2:  n_state = S_RW;
            S_RW:   n_state = (r_b1 && w_rd) ? S_OUT : S_WR1;
            S_WR1:  n_state = S_WR2;
            S_WR2:  n_state = S_OUT;
            S_OUT:  if (!r_ovalid || m_axis_tready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR; r_clr <= '0; r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLR) r_clr <= r_clr + 1'b1;
            if (r_state == S_OUT && (!r_ovalid || m_axis_tready)) r_ovalid <= 1'b1;
            else if (m_axis_tready) r_ovalid <= 1'b0;
        end
        if (r_state == S_IDLE && s_axis_tvalid) r_in <= s_axis_tdata;
        if (r_state == S_CHK) begin
            r_rem <= '0; r_bit <= 4'(OFFSET_W - 1); r_status <= ST_BAD;
        end
        if (r_state == S_MOD) begin
            // restoring division, one offset bit per cycle
            r_rem <= w_trial[PREFIX_W] ? PREFIX_W'({r_rem, w_off[r_bit]})
                                       : w_trial[PREFIX_W-1:0];
            r_bit <= r_bit - 4'd1;
        end
        if (r_state == S_H1 && w_hdone) r_p1 <= w_hash[BLOOM_INDEX_BITS-1:0];
        if (r_state == S_H2 && w_hdone) r_p2 <= w_hash[BLOOM_INDEX_BITS-1:0];
        if (r_state == S_RD2) r_b1 <= w_rd;
        if (r_state == S_RW) r_status <= (r_b1 && w_rd) ? ST_DUP : ST_NEW;
        if (r_state == S_OUT && (!r_ovalid || m_axis_tready)) begin
            if (r_status == ST_BAD) m_axis_tdata <= {7'd0, 143'd0, ST_BAD};
            else m_axis_tdata <= {7'd0, r_in[186:123], r_in[122:59],
                                  INDEX_W'(r_rem), r_status};
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_ovalid;
endmodule
`default_nettype wire
